[sv/tgp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgp_pkg: shared types and constants of the turtle grid plotter
// Cell codes, command codes, sequencer states, bus layouts and grid clamps.
// ----------------------------------------------------------------------------
package tgp_pkg;

  // Store geometry
  localparam int MaxRows = 32;
  localparam int MaxCols = 128;
  localparam int RowW    = $clog2(MaxRows);
  localparam int ColW    = $clog2(MaxCols);
  localparam int AddrW   = RowW + ColW;
  localparam int Depth   = MaxRows * MaxCols;

  // Field and register widths
  localparam int OpW      = 3;
  localparam int StepW    = 8;
  localparam int HeadW    = 2;
  localparam int CellW    = 2;
  localparam int RowsW    = 6;
  localparam int ColsW    = 8;
  localparam int CntW     = (ColW > RowW) ? ColW : RowW;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;
  localparam int OutUsedW = ColW + RowW + HeadW + 1 + CellW;

  localparam logic [RowsW-1:0] ROWS_RESET = 6'd25;
  localparam logic [ColsW-1:0] COLS_RESET = 8'd100;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_GRID_COLS = 1'b1;

  typedef logic [CellW-1:0] cell_t;
  localparam cell_t CELL_BLANK = 2'd0;
  localparam cell_t CELL_TRAIL = 2'd1;
  localparam cell_t CELL_UP    = 2'd2;
  localparam cell_t CELL_DOWN  = 2'd3;

  typedef enum logic [OpW-1:0] {
    OP_INIT   = 3'd0,
    OP_PEN    = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_LEFT   = 3'd3,
    OP_FWD    = 3'd4,
    OP_FINISH = 3'd5,
    OP_READ   = 3'd6
  } op_t;

  typedef enum logic [HeadW-1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } head_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DRAW,
    ST_LOOK,
    ST_PLACE,
    ST_RDATA,
    ST_CURSOR,
    ST_DONE
  } state_t;

  // Grid size in use, already clamped
  typedef struct packed {
    logic [RowsW-1:0] rows;
    logic [ColsW-1:0] cols;
  } grid_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [StepW-1:0] steps;
    logic [RowW-1:0]  read_row;
    logic [ColW-1:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    cell_t            wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [ColW-1:0]  pos_x;
    logic [RowW-1:0]  pos_y;
    logic [HeadW-1:0] heading;
    logic             pen_down;
    cell_t            cell_value;
  } result_t;

  function automatic logic [RowsW-1:0] rows_in_use(input logic [RowsW-1:0] r);
    logic [RowsW-1:0] v;
    v = r;
    if (r == '0) v = RowsW'(1);
    else if (r > RowsW'(MaxRows)) v = RowsW'(MaxRows);
    return v;
  endfunction

  function automatic logic [ColsW-1:0] cols_in_use(input logic [ColsW-1:0] c);
    logic [ColsW-1:0] v;
    v = c;
    if (c == '0) v = ColsW'(1);
    else if (c > ColsW'(MaxCols)) v = ColsW'(MaxCols);
    return v;
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] row,
                                                 input logic [ColW-1:0] col);
    return {row, col};
  endfunction

endpackage : tgp_pkg
`default_nettype wire

[sv/tgp_cell_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgp_cell_mem: cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tgp_cell_mem
  import tgp_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output cell_t         rd_data
);

  cell_t mem_r [Depth];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem_r[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule : tgp_cell_mem
`default_nettype wire

[sv/tgp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgp_ctrl: command sequencer
// Holds the turtle state and drives the cell store one access per cycle.
// ----------------------------------------------------------------------------
module tgp_ctrl
  import tgp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire cmd_t  cmd,
  output logic       in_ready,
  input  wire grid_t grid,
  output mem_req_t   mem_req,
  input  wire cell_t rd_data,
  output result_t    res,
  input  wire logic  res_ready
);

  state_t            state_r, state_nxt;
  logic [OpW-1:0]    op_r, op_nxt;
  logic [StepW-1:0]  steps_r, steps_nxt;
  logic [RowW-1:0]   rrow_r, rrow_nxt;
  logic [ColW-1:0]   rcol_r, rcol_nxt;
  logic [ColW-1:0]   pos_x_r, pos_x_nxt;
  logic [RowW-1:0]   pos_y_r, pos_y_nxt;
  logic [HeadW-1:0]  heading_r, heading_nxt;
  logic              pen_r, pen_nxt;
  cell_t             saved_r, saved_nxt;
  cell_t             value_r, value_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [AddrW-1:0]  clr_r, clr_nxt;
  logic              init_r, init_nxt;

  logic [CntW-1:0]   room, span, mv_amt;
  logic [ColW-1:0]   mv_x, start_x;
  logic [RowW-1:0]   mv_y, start_y;
  logic [ColsW-1:0]  col_lim, half_cols;
  logic [RowsW-1:0]  row_lim, half_rows;
  logic [AddrW-1:0]  pos_addr;

  assign pos_addr  = cell_addr(pos_y_r, pos_x_r);
  assign col_lim   = grid.cols - ColsW'(1);
  assign row_lim   = grid.rows - RowsW'(1);
  assign half_cols = grid.cols >> 1;
  assign half_rows = grid.rows >> 1;

  // Room to the edge, clipped step count and the moved position
  always_comb begin
    room = '0;
    case (heading_r)
      HEAD_UP:    room = CntW'(pos_y_r);
      HEAD_RIGHT: if ({1'b0, pos_x_r} < col_lim) room = CntW'(col_lim - {1'b0, pos_x_r});
      HEAD_DOWN:  if ({1'b0, pos_y_r} < row_lim) room = CntW'(row_lim - {1'b0, pos_y_r});
      HEAD_LEFT:  room = CntW'(pos_x_r);
      default:    room = '0;
    endcase
    span = (steps_r < StepW'(room)) ? CntW'(steps_r) : room;

    mv_amt = (state_r == ST_DRAW) ? CntW'(1) : span;
    mv_x   = pos_x_r;
    mv_y   = pos_y_r;
    case (heading_r)
      HEAD_UP:    mv_y = pos_y_r - RowW'(mv_amt);
      HEAD_RIGHT: mv_x = pos_x_r + ColW'(mv_amt);
      HEAD_DOWN:  mv_y = pos_y_r + RowW'(mv_amt);
      HEAD_LEFT:  mv_x = pos_x_r - ColW'(mv_amt);
      default:    mv_x = pos_x_r;
    endcase

    start_x = (half_cols != '0) ? ColW'(half_cols - ColsW'(1)) : '0;
    start_y = (half_rows != '0) ? RowW'(half_rows - RowsW'(1)) : '0;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AddrW'(Depth - 1)) state_nxt = init_r ? ST_CURSOR : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_r)
          OP_INIT: state_nxt = ST_CLEAR;
          OP_FWD:  state_nxt = pen_r ? ST_DRAW : ST_LOOK;
          OP_READ: state_nxt = ST_RDATA;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_DRAW: begin
        if (cnt_r == '0) state_nxt = ST_DONE;
      end
      ST_LOOK:   state_nxt = ST_PLACE;
      ST_PLACE:  state_nxt = ST_DONE;
      ST_RDATA:  state_nxt = ST_DONE;
      ST_CURSOR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: store access, handshake, result
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = pos_addr;
    mem_req.waddr = pos_addr;
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = CELL_BLANK;
      end
      ST_EXEC: begin
        case (op_r)
          OP_PEN: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = pen_r ? CELL_UP : CELL_DOWN;
          end
          OP_FWD: begin
            mem_req.we    = !pen_r;
            mem_req.wdata = saved_r;
          end
          OP_FINISH: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = saved_r;
          end
          OP_READ: mem_req.raddr = cell_addr(rrow_r, rcol_r);
          default: mem_req.we = 1'b0;
        endcase
      end
      ST_DRAW: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = (cnt_r == '0) ? CELL_DOWN : CELL_TRAIL;
      end
      ST_PLACE, ST_CURSOR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = CELL_UP;
      end
      default: mem_req.we = 1'b0;
    endcase

    in_ready       = (state_r == ST_IDLE);
    res.valid      = (state_r == ST_DONE);
    res.pos_x      = pos_x_r;
    res.pos_y      = pos_y_r;
    res.heading    = heading_r;
    res.pen_down   = pen_r;
    res.cell_value = value_r;
  end

  // Datapath next values
  always_comb begin
    op_nxt      = op_r;
    steps_nxt   = steps_r;
    rrow_nxt    = rrow_r;
    rcol_nxt    = rcol_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    heading_nxt = heading_r;
    pen_nxt     = pen_r;
    saved_nxt   = saved_r;
    value_nxt   = value_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    init_nxt    = init_r;
    case (state_r)
      ST_CLEAR: clr_nxt = clr_r + AddrW'(1);
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = cmd.op;
          steps_nxt = cmd.steps;
          rrow_nxt  = cmd.read_row;
          rcol_nxt  = cmd.read_col;
        end
      end
      ST_EXEC: begin
        value_nxt = CELL_BLANK;
        case (op_r)
          OP_INIT: begin
            pos_x_nxt   = start_x;
            pos_y_nxt   = start_y;
            heading_nxt = HEAD_UP;
            pen_nxt     = 1'b0;
            saved_nxt   = CELL_BLANK;
            clr_nxt     = '0;
            init_nxt    = 1'b1;
          end
          OP_PEN: begin
            pen_nxt = !pen_r;
            if (!pen_r) saved_nxt = CELL_TRAIL;
          end
          OP_RIGHT: heading_nxt = heading_r + HeadW'(1);
          OP_LEFT:  heading_nxt = heading_r - HeadW'(1);
          OP_FWD: begin
            cnt_nxt = span;
            if (!pen_r) begin
              pos_x_nxt = mv_x;
              pos_y_nxt = mv_y;
            end
          end
          default: cnt_nxt = cnt_r;
        endcase
      end
      ST_DRAW: begin
        if (cnt_r == '0) begin
          saved_nxt = CELL_TRAIL;
        end else begin
          pos_x_nxt = mv_x;
          pos_y_nxt = mv_y;
          cnt_nxt   = cnt_r - CntW'(1);
        end
      end
      ST_PLACE:  saved_nxt = rd_data;
      ST_RDATA:  value_nxt = rd_data;
      ST_CURSOR: init_nxt = 1'b0;
      default:   clr_nxt = clr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= HEAD_UP;
      pen_r     <= 1'b0;
      saved_r   <= CELL_BLANK;
      value_r   <= CELL_BLANK;
      cnt_r     <= '0;
      clr_r     <= '0;
      init_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      heading_r <= heading_nxt;
      pen_r     <= pen_nxt;
      saved_r   <= saved_nxt;
      value_r   <= value_nxt;
      cnt_r     <= cnt_nxt;
      clr_r     <= clr_nxt;
      init_r    <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    steps_r <= steps_nxt;
    rrow_r  <= rrow_nxt;
    rcol_r  <= rcol_nxt;
  end

endmodule : tgp_ctrl
`default_nettype wire

[sv/turtle_grid_plotter_unit.sv]
`default_nettype none
// Throughput: one command at a time; the next is accepted only after the previous
//   result has been handed to the output register.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass over
//   all 4096 cells blanks the store with in_tready low; configuration writes are
//   taken throughout.
// ----------------------------------------------------------------------------
// turtle_grid_plotter_unit: turtle-graphics plotter on a 2-bit cell grid
// Stream command in, one status transfer out per command; cell store in a
// synchronous memory, updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
module turtle_grid_plotter_unit
  import tgp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Command channel
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // [2:0] operation, [10:3] steps, [15:11] read_row, [22:16] read_col, [23] zero
  input  wire logic [InDataW-1:0]  in_tdata,
  // Result channel
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [6:0] pos_x, [11:7] pos_y, [13:12] heading, [14] pen_down,
  // [16:15] cell_value, [23:17] zero
  output logic [OutDataW-1:0]      out_tdata,
  // Configuration write port
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic [RowsW-1:0]    grid_rows_r;
  logic [ColsW-1:0]    grid_cols_r;
  grid_t               grid;
  cmd_t                cmd;
  mem_req_t            mem_req;
  cell_t               rd_data;
  result_t             res;
  logic                res_ready;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OutDataW-1:0] out_tdata_r, out_tdata_nxt;

  // Configuration registers; act at once, clamped to the store size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROWS_RESET;
      grid_cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_data[RowsW-1:0];
        REG_GRID_COLS: grid_cols_r <= cfg_data[ColsW-1:0];
        default:       grid_rows_r <= grid_rows_r;
      endcase
    end
  end

  assign grid.rows = rows_in_use(grid_rows_r);
  assign grid.cols = cols_in_use(grid_cols_r);

  // Unpack the command transfer
  assign cmd.op       = in_tdata[OpW-1:0];
  assign cmd.steps    = in_tdata[OpW +: StepW];
  assign cmd.read_row = in_tdata[OpW+StepW +: RowW];
  assign cmd.read_col = in_tdata[OpW+StepW+RowW +: ColW];

  tgp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .cmd       (cmd),
    .in_ready  (in_tready),
    .grid      (grid),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_ready (res_ready)
  );

  tgp_cell_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: load a finished result when the slot is empty or drains
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (res_ready) begin
      out_tvalid_nxt = res.valid;
    end
    if (res_ready && res.valid) begin
      out_tdata_nxt = {(OutDataW - OutUsedW)'(0), res.cell_value, res.pen_down,
                       res.heading, res.pos_y, res.pos_x};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule : turtle_grid_plotter_unit
`default_nettype wire

[sv/tgp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgp_checker: port-level checks for the turtle grid plotter
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module tgp_checker
  import tgp_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tvalid,
  input wire logic                in_tready,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata
);

  logic [1:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Count commands taken whose result has not yet been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("command taken while the previous one is still in work");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pend_r != 2'd0)
    else $error("result transfer without a pending command");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("command accepted before the store is cleared");

endmodule : tgp_checker

bind turtle_grid_plotter_unit tgp_checker u_tgp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[tb/turtle_grid_plotter_monitor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// turtle_grid_plotter_monitor: status predictor and comparator
// Watches the command, status and configuration ports of the plotter. It
// keeps its own picture of the cell grid and the turtle, predicts the status
// of every accepted command and compares each status transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module turtle_grid_plotter_monitor
  import tgp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,
  input  wire logic                out_tvalid,
  input  wire logic                out_tready,
  input  wire logic [OutDataW-1:0] out_tdata,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending_results
);

  // Laid out as on out_tdata: pos_x in the lowest bits
  typedef struct packed {
    cell_t            cell_value;
    logic             pen_down;
    head_t            heading;
    logic [RowW-1:0]  pos_y;
    logic [ColW-1:0]  pos_x;
  } status_t;

  cell_t            grid_cells [Depth];
  int unsigned      cur_col;
  int unsigned      cur_row;
  head_t            cur_head;
  logic             pen_lowered;
  cell_t            under_cursor;
  logic [RowsW-1:0] rows_reg;
  logic [ColsW-1:0] cols_reg;
  status_t          status_q [$];
  status_t          want;
  status_t          got;
  int               mismatches = 0;

  function automatic int unsigned cell_index(input int unsigned row, input int unsigned col);
    return row * MaxCols + col;
  endfunction

  function automatic void step_turtle();
    case (cur_head)
      HEAD_UP:    cur_row--;
      HEAD_RIGHT: cur_col++;
      HEAD_DOWN:  cur_row++;
      default:    cur_col--;
    endcase
  endfunction

  function automatic status_t predict_status(input logic [InDataW-1:0] cmd);
    op_t             op;
    int unsigned     steps;
    int unsigned     rows;
    int unsigned     cols;
    int unsigned     room;
    int unsigned     moves;
    logic [RowW-1:0] rrow;
    logic [ColW-1:0] rcol;
    status_t         st;
    op    = op_t'(cmd[2:0]);
    steps = 32'(cmd[10:3]);
    rrow  = cmd[15:11];
    rcol  = cmd[22:16];
    rows  = (rows_reg == '0) ? 1 : (32'(rows_reg) > MaxRows) ? MaxRows : 32'(rows_reg);
    cols  = (cols_reg == '0) ? 1 : (32'(cols_reg) > MaxCols) ? MaxCols : 32'(cols_reg);
    st.cell_value = CELL_BLANK;
    case (op)
      OP_INIT: begin
        for (int i = 0; i < Depth; i++) grid_cells[i] = CELL_BLANK;
        cur_col      = (cols / 2 >= 1) ? cols / 2 - 1 : 0;
        cur_row      = (rows / 2 >= 1) ? rows / 2 - 1 : 0;
        cur_head     = HEAD_UP;
        pen_lowered  = 1'b0;
        under_cursor = CELL_BLANK;
        grid_cells[cell_index(cur_row, cur_col)] = CELL_UP;
      end
      OP_PEN: begin
        pen_lowered = ~pen_lowered;
        grid_cells[cell_index(cur_row, cur_col)] = pen_lowered ? CELL_DOWN : CELL_UP;
        if (pen_lowered) under_cursor = CELL_TRAIL;
      end
      OP_RIGHT: cur_head = head_t'(HeadW'(cur_head + 1));
      OP_LEFT:  cur_head = head_t'(HeadW'(cur_head + 3));
      OP_FWD: begin
        case (cur_head)
          HEAD_UP:    room = cur_row;
          HEAD_RIGHT: room = (cur_col < cols - 1) ? cols - 1 - cur_col : 0;
          HEAD_DOWN:  room = (cur_row < rows - 1) ? rows - 1 - cur_row : 0;
          default:    room = cur_col;
        endcase
        moves = (steps < room) ? steps : room;
        if (pen_lowered) begin
          grid_cells[cell_index(cur_row, cur_col)] = CELL_TRAIL;
          repeat (moves) begin
            step_turtle();
            grid_cells[cell_index(cur_row, cur_col)] = CELL_TRAIL;
          end
          under_cursor = CELL_TRAIL;
          grid_cells[cell_index(cur_row, cur_col)] = CELL_DOWN;
        end else begin
          grid_cells[cell_index(cur_row, cur_col)] = under_cursor;
          repeat (moves) step_turtle();
          under_cursor = grid_cells[cell_index(cur_row, cur_col)];
          grid_cells[cell_index(cur_row, cur_col)] = CELL_UP;
        end
      end
      OP_FINISH: grid_cells[cell_index(cur_row, cur_col)] = under_cursor;
      OP_READ:   st.cell_value = grid_cells[cell_index(32'(rrow), 32'(rcol))];
      default: ;
    endcase
    st.pos_x    = cur_col[ColW-1:0];
    st.pos_y    = cur_row[RowW-1:0];
    st.heading  = cur_head;
    st.pen_down = pen_lowered;
    return st;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Depth; i++) grid_cells[i] = CELL_BLANK;
      cur_col      = 0;
      cur_row      = 0;
      cur_head     = HEAD_UP;
      pen_lowered  = 1'b0;
      under_cursor = CELL_BLANK;
      rows_reg     = ROWS_RESET;
      cols_reg     = COLS_RESET;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_ROWS) rows_reg = cfg_data[RowsW-1:0];
        else cols_reg = cfg_data[ColsW-1:0];
      end
      if (out_tvalid && out_tready) begin
        got = status_t'(out_tdata[OutUsedW-1:0]);
        if (status_q.size() == 0) begin
          mismatches++;
          $display("%0t: status transfer with no command outstanding, expected none, actual %h",
                   $time, got);
        end else begin
          want = status_q.pop_front();
          check_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
          check_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
          check_field("heading", 32'(want.heading), 32'(got.heading));
          check_field("pen_down", 32'(want.pen_down), 32'(got.pen_down));
          check_field("cell_value", 32'(want.cell_value), 32'(got.cell_value));
        end
      end
      if (in_tvalid && in_tready) status_q.push_back(predict_status(in_tdata));
    end
    fail_count      <= mismatches;
    pending_results <= status_q.size();
  end

endmodule : turtle_grid_plotter_monitor
`default_nettype wire

[tb/turtle_grid_plotter_unit_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// turtle_grid_plotter_unit_tb: top-level testbench of the turtle grid plotter
// Drives directed and random command streams under several grid sizes and
// three idle patterns, with a long status-side hold-off and a full drain
// pause; the monitor predicts and compares every status transfer.
// ----------------------------------------------------------------------------
module turtle_grid_plotter_unit_tb;
  import tgp_pkg::*;

  localparam int WatchdogLimit = 40000;  // outlasts the quiet init sweep of the store
  localparam int HoldCycles    = 400;
  localparam int SegItems      = 320;
  localparam int Segments      = 6;
  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;

  // Grid sizes per segment: extremes, out-of-range values that clamp, and a
  // shrink without init so the turtle starts outside the grid in use
  localparam int SegRows [Segments] = '{32, 1, 63, 4, 0, 9};
  localparam int SegCols [Segments] = '{128, 1, 255, 6, 0, 17};
  localparam bit SegInit [Segments] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_tvalid = 1'b0;
  logic [InDataW-1:0]  in_tdata  = '0;
  logic                out_tready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  wire logic                in_tready;
  wire logic                out_tvalid;
  wire logic [OutDataW-1:0] out_tdata;

  int fail_count;
  int pending_results;
  int snd_idle_pct = 7;
  int rcv_idle_pct = 57;
  int rows_used    = 25;
  int cols_used    = 100;
  int quiet_cycles = 0;
  int hold_left    = 0;
  logic hold_go    = 1'b0;
  logic hold_done  = 1'b0;

  always #5 clk = ~clk;

  turtle_grid_plotter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  turtle_grid_plotter_monitor plot_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Status side: random back-pressure, plus one long hold-off counted here
  // once the stimulus raises hold_go. The block fills up and must stall its
  // command input meanwhile.
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HoldCycles;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Watchdog: end the run when no transfer happens on either channel for too long
  initial begin : watchdog
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one command, idling first at the sender's rate; return at the edge
  // of its transfer so a follow-up command can go out back to back.
  task automatic send_cmd(input logic [OpW-1:0] op, input logic [StepW-1:0] steps,
                          input logic [RowW-1:0] rrow, input logic [ColW-1:0] rcol);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, rcol, rrow, steps, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted status has arrived, then let
  // the block settle.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both grid registers; only called while the block is idle.
  task automatic set_grid(input int rows, input int cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= CfgDataW'(rows);
    @(posedge clk);
    cfg_index <= REG_GRID_COLS;
    cfg_data  <= CfgDataW'(cols);
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_used = (rows == 0) ? 1 : (rows > MaxRows) ? MaxRows : rows;
    cols_used = (cols == 0) ? 1 : (cols > MaxCols) ? MaxCols : cols;
  endtask

  // Mostly walking: turns, pen changes, short moves and reads inside the grid
  // in use so trails get seen. Inits are rare since each sweeps the store.
  // Unused fields always carry random bits.
  task automatic send_random();
    int              pick;
    logic [OpW-1:0]  op;
    logic [StepW-1:0] steps;
    logic [RowW-1:0] rrow;
    logic [ColW-1:0] rcol;
    pick  = $urandom_range(0, 99);
    steps = StepW'($urandom_range(0, 255));
    rrow  = RowW'($urandom_range(0, 31));
    rcol  = ColW'($urandom_range(0, 127));
    if (pick < 2) op = OP_INIT;
    else if (pick < 10) op = OP_PEN;
    else if (pick < 22) op = OP_RIGHT;
    else if (pick < 34) op = OP_LEFT;
    else if (pick < 64) begin
      op   = OP_FWD;
      pick = $urandom_range(0, 99);
      if (pick < 60) steps = StepW'($urandom_range(0, 7));
      else if (pick < 85) steps = StepW'($urandom_range(0, cols_used));
    end else if (pick < 70) op = OP_FINISH;
    else if (pick < 98) begin
      op = OP_READ;
      if ($urandom_range(0, 99) < 70) begin
        rrow = RowW'($urandom_range(0, rows_used - 1));
        rcol = ColW'($urandom_range(0, cols_used - 1));
      end
    end else op = OP_UNUSED;
    send_cmd(op, steps, rrow, rcol);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset grid of 25 x 100. Commands before init act on the
    // blank store with the turtle at the origin.
    send_cmd(OP_READ,   8'd0,   5'd0,  7'd0);
    send_cmd(OP_FWD,    8'd255, 5'd0,  7'd0);    // heading up at row 0: no room
    send_cmd(OP_PEN,    8'd0,   5'd0,  7'd0);
    send_cmd(OP_RIGHT,  8'd0,   5'd0,  7'd0);
    send_cmd(OP_FWD,    8'd5,   5'd0,  7'd0);
    send_cmd(OP_READ,   8'd0,   5'd0,  7'd3);
    send_cmd(OP_FINISH, 8'd0,   5'd0,  7'd0);
    send_cmd(OP_UNUSED, 8'd255, 5'd31, 7'd127);  // unused code changes nothing
    send_cmd(OP_INIT,   8'd0,   5'd0,  7'd0);
    send_cmd(OP_READ,   8'd0,   5'd11, 7'd49);   // cursor after init
    send_cmd(OP_PEN,    8'd0,   5'd0,  7'd0);
    send_cmd(OP_FWD,    8'd255, 5'd0,  7'd0);    // clipped at the top edge
    send_cmd(OP_READ,   8'd0,   5'd0,  7'd49);
    send_cmd(OP_READ,   8'd0,   5'd5,  7'd49);
    send_cmd(OP_LEFT,   8'd0,   5'd0,  7'd0);
    send_cmd(OP_FWD,    8'd0,   5'd0,  7'd0);
    send_cmd(OP_PEN,    8'd0,   5'd0,  7'd0);
    send_cmd(OP_FWD,    8'd3,   5'd0,  7'd0);    // pen up: restore the trail below
    send_cmd(OP_READ,   8'd0,   5'd0,  7'd49);
    send_cmd(OP_LEFT,   8'd0,   5'd0,  7'd0);
    send_cmd(OP_FWD,    8'd255, 5'd0,  7'd0);    // clipped at the bottom edge
    send_cmd(OP_READ,   8'd0,   5'd31, 7'd127);  // inside store, outside grid
    send_cmd(OP_FINISH, 8'd0,   5'd0,  7'd0);
    send_cmd(OP_READ,   8'd0,   5'd24, 7'd46);

    // Random segments: each pair of segments shares an idle pattern
    for (int seg = 0; seg < Segments; seg++) begin
      settle();
      case (seg / 2)
        0: begin snd_idle_pct = 7;  rcv_idle_pct <= 57; end
        1: begin snd_idle_pct = 57; rcv_idle_pct <= 7;  end
        default: begin snd_idle_pct = 0; rcv_idle_pct <= 0; end
      endcase
      set_grid(SegRows[seg], SegCols[seg]);
      if (SegInit[seg]) send_cmd(OP_INIT, 8'd0, 5'd0, 7'd0);
      for (int i = 0; i < SegItems; i++) begin
        if (seg == 0 && i == 40) hold_go <= 1'b1;
        if (i == SegItems / 2) settle();   // sender pause until fully drained
        send_random();
      end
    end

    settle();
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : turtle_grid_plotter_unit_tb
`default_nettype wire
